// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same check but also active during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/crc8fr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package crc8fr_pkg;

    localparam logic [7:0] START_BYTE   = 8'hFE;
    localparam logic [7:0] UPDATE_INSTR = 8'h18;
    localparam logic [7:0] ACK_LENGTH   = 8'h05;
    localparam logic [7:0] CRC_POLY     = 8'h31;
    localparam logic [7:0] BODY_START   = 8'd6;
    localparam logic [7:0] SEQ_INDEX    = 8'd4;
    localparam logic [7:0] STATUS_INDEX = 8'd5;
    localparam logic [7:0] STATUS_FINAL = 8'd1;

    // register indexes on the APB port
    localparam logic [1:0] REG_OWN_ADDR  = 2'd0;
    localparam logic [1:0] REG_HOST_ADDR = 2'd1;
    localparam logic [1:0] REG_STRIDE    = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_BODY    = 2'd1,
        KIND_VERDICT = 2'd2,
        KIND_ACK     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        UPD_IDLE      = 2'd0,
        UPD_RECEIVING = 2'd1,
        UPD_DONE_OK   = 2'd2,
        UPD_DONE_LOSS = 2'd3
    } t_upd;

    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] host_address;
        logic [7:0] page_stride;
    } t_cfg;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
        logic [7:0] offset;
        logic       ok;
        logic       upd;
        logic [7:0] instr;
        logic [7:0] seq;
        logic [7:0] status;
        logic [7:0] body_len;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  body_offset;
        logic        frame_ok;
        logic        is_update;
        logic        write_page;
        logic [15:0] page_address;
        logic [7:0]  body_length;
        t_upd        update_state;
        logic [7:0]  sequence_number;
        logic [7:0]  instruction_code;
        logic        last;
    } t_result;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/crc8fr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rx_valid,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_full,
    input  wire logic [7:0]        i_own_address,
    output crc8fr_pkg::t_cmd       o_cmd,
    output logic                   o_push
);
    import crc8fr_pkg::*;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_DEST  = 6'b000100,
        PH_SRC   = 6'b001000,
        PH_INSTR = 6'b010000,
        PH_BODY  = 6'b100000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_len, n_len;
    logic [7:0] r_idx, n_idx;
    logic [7:0] r_dest, n_dest;
    logic [7:0] r_instr, n_instr;
    logic [7:0] r_seq, n_seq;
    logic [7:0] r_status, n_status;
    logic [7:0] r_crc, n_crc;

    logic       accept;
    logic [7:0] idx_inc;
    logic [7:0] crc_upd;

    assign accept  = i_rx_valid && !i_full;
    assign idx_inc = r_idx + 8'd1;
    assign crc_upd = crc_step(r_crc, i_rx_byte);

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_idx    = r_idx;
        n_dest   = r_dest;
        n_instr  = r_instr;
        n_seq    = r_seq;
        n_status = r_status;
        n_crc    = r_crc;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == START_BYTE) n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_idx   = 8'd0;
                    n_crc   = (i_rx_byte != 8'd0) ? crc_step(8'd0, i_rx_byte) : 8'd0;
                    n_phase = PH_DEST;
                end
                PH_DEST, PH_SRC, PH_INSTR: begin
                    n_idx = idx_inc;
                    if (idx_inc < r_len) n_crc = crc_upd;
                    if (r_phase == PH_DEST) begin
                        n_dest  = i_rx_byte;
                        n_phase = PH_SRC;
                    end else if (r_phase == PH_SRC) begin
                        n_phase = PH_INSTR;
                    end else begin
                        n_instr = i_rx_byte;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_idx = idx_inc;
                    if (idx_inc == SEQ_INDEX)    n_seq    = i_rx_byte;
                    if (idx_inc == STATUS_INDEX) n_status = i_rx_byte;
                    if (idx_inc < r_len) begin
                        n_crc = crc_upd;
                        if (idx_inc >= BODY_START) begin
                            o_push        = 1'b1;
                            o_cmd.is_end  = 1'b0;
                            o_cmd.data    = i_rx_byte;
                            o_cmd.offset  = idx_inc - BODY_START;
                        end
                    end else begin
                        // this byte is the CRC; a short frame may latch it as seq too
                        o_push         = 1'b1;
                        o_cmd.is_end   = 1'b1;
                        o_cmd.ok       = (r_dest == i_own_address) && (i_rx_byte == r_crc);
                        o_cmd.upd      = o_cmd.ok && (r_instr == UPDATE_INSTR);
                        o_cmd.instr    = r_instr;
                        o_cmd.seq      = n_seq;
                        o_cmd.status   = n_status;
                        o_cmd.body_len = (r_len >= BODY_START) ? (r_len - BODY_START) : 8'd0;
                        n_phase        = PH_HUNT;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_len    <= '0;
            r_idx    <= '0;
            r_dest   <= '0;
            r_instr  <= '0;
            r_seq    <= '0;
            r_status <= '0;
            r_crc    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_dest   <= n_dest;
            r_instr  <= n_instr;
            r_seq    <= n_seq;
            r_status <= n_status;
            r_crc    <= n_crc;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/crc8fr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  crc8fr_pkg::t_cmd      i_push_cmd,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output crc8fr_pkg::t_cmd      o_head
);
    import crc8fr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_push_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/crc8fr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  crc8fr_pkg::t_cfg      i_cfg,
    input  crc8fr_pkg::t_cmd      i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output crc8fr_pkg::t_result   o_res
);
    import crc8fr_pkg::*;

    localparam logic [2:0] STEP_VERDICT = 3'd0;
    localparam logic [2:0] STEP_START   = 3'd1;
    localparam logic [2:0] STEP_LEN     = 3'd2;
    localparam logic [2:0] STEP_HOST    = 3'd3;
    localparam logic [2:0] STEP_OWN     = 3'd4;
    localparam logic [2:0] STEP_INSTR   = 3'd5;
    localparam logic [2:0] STEP_SEQ     = 3'd6;
    localparam logic [2:0] STEP_CRC     = 3'd7;

    logic       r_valid, n_valid;
    t_result    r_res, n_res;
    logic [2:0] r_step, n_step;
    logic [7:0] r_ack_crc, n_ack_crc;
    logic [7:0] r_last_seq, n_last_seq;
    logic       r_loss, n_loss;
    t_upd       r_prog, n_prog;

    logic        load;
    logic [7:0]  ack_byte;
    logic [15:0] page_prod;
    logic [8:0]  seq_plus;

    assign load      = !i_empty && (!r_valid || !i_stall);
    assign page_prod = 16'(i_head.seq * i_cfg.page_stride);
    assign seq_plus  = {1'b0, r_last_seq} + 9'd1;

    always_comb begin
        case (r_step)
            STEP_START: ack_byte = START_BYTE;
            STEP_LEN:   ack_byte = ACK_LENGTH;
            STEP_HOST:  ack_byte = i_cfg.host_address;
            STEP_OWN:   ack_byte = i_cfg.own_address;
            STEP_INSTR: ack_byte = UPDATE_INSTR;
            STEP_SEQ:   ack_byte = i_head.seq;
            default:    ack_byte = r_ack_crc;
        endcase
    end

    always_comb begin
        n_valid    = r_valid;
        n_res      = r_res;
        n_step     = r_step;
        n_ack_crc  = r_ack_crc;
        n_last_seq = r_last_seq;
        n_loss     = r_loss;
        n_prog     = r_prog;
        o_pop      = 1'b0;
        if (r_valid && !i_stall) n_valid = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            n_res   = '0;
            if (!i_head.is_end) begin
                n_res.kind        = KIND_BODY;
                n_res.data_byte   = i_head.data;
                n_res.body_offset = i_head.offset;
                n_res.last        = 1'b1;
                o_pop             = 1'b1;
            end else if (r_step == STEP_VERDICT) begin
                n_res.write_page = 1'b0;
                if (i_head.upd) begin
                    n_prog = UPD_RECEIVING;
                    if (i_head.seq == 8'd0) begin
                        n_loss           = 1'b0;
                        n_last_seq       = 8'd0;
                        n_res.write_page = 1'b1;
                    end else if (seq_plus == {1'b0, i_head.seq}) begin
                        n_last_seq       = i_head.seq;
                        n_res.write_page = 1'b1;
                    end else if (r_last_seq != i_head.seq) begin
                        n_loss = 1'b1;
                    end
                    if (i_head.status == STATUS_FINAL) begin
                        n_prog = n_loss ? UPD_DONE_LOSS : UPD_DONE_OK;
                    end
                    n_res.page_address    = page_prod;
                    n_res.sequence_number = i_head.seq;
                    n_step                = STEP_START;
                end else begin
                    o_pop = 1'b1;
                end
                n_res.kind             = KIND_VERDICT;
                n_res.frame_ok         = i_head.ok;
                n_res.is_update        = i_head.upd;
                n_res.body_length      = i_head.body_len;
                n_res.update_state     = n_prog;
                n_res.instruction_code = i_head.instr;
                n_res.last             = !i_head.upd;
            end else begin
                // acknowledge frame, CRC accumulated over length..seq
                n_res.kind      = KIND_ACK;
                n_res.data_byte = ack_byte;
                if (r_step == STEP_START) n_ack_crc = 8'd0;
                else if (r_step != STEP_CRC) n_ack_crc = crc_step(r_ack_crc, ack_byte);
                if (r_step == STEP_CRC) begin
                    n_res.last = 1'b1;
                    n_step     = STEP_VERDICT;
                    o_pop      = 1'b1;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_step     <= STEP_VERDICT;
            r_last_seq <= '0;
            r_loss     <= 1'b0;
            r_prog     <= UPD_IDLE;
        end else begin
            r_valid    <= n_valid;
            r_step     <= n_step;
            r_last_seq <= n_last_seq;
            r_loss     <= n_loss;
            r_prog     <= n_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_ack_crc <= n_ack_crc;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ===== rtl/core/crc8_frame_receiver_with_update_seq_unit.sv =====
// The byte that causes a result is first written into the command queue; the result is then registered at the output.
// Throughput: one received byte per cycle while the command queue is not full (o_rx_stall);
// a body byte or plain verdict gives one result, an accepted update frame end gives a verdict followed by 7 ack bytes.
// The command queue (QUEUE_DEPTH entries) absorbs bursts while the output drains.
// Reset (synchronous, active low) returns to hunting, clears sequence state and
// loads own_address 4, host_address 1, page_stride 249.
`timescale 1ns / 1ps
`default_nettype none
module crc8_frame_receiver_with_update_seq_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [7:0]       o_body_offset,
    output logic             o_frame_ok,
    output logic             o_is_update,
    output logic             o_write_page,
    output logic [15:0]      o_page_address,
    output logic [7:0]       o_body_length,
    output logic [1:0]       o_update_state,
    output logic [7:0]       o_sequence_number,
    output logic [7:0]       o_instruction_code,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import crc8fr_pkg::*;

    t_cfg    r_cfg;
    t_cmd    push_cmd, head;
    logic    push, full, empty, pop;
    t_result res;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address  <= 8'd4;
            r_cfg.host_address <= 8'd1;
            r_cfg.page_stride  <= 8'd249;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_OWN_ADDR:  r_cfg.own_address  <= pwdata[7:0];
                REG_HOST_ADDR: r_cfg.host_address <= pwdata[7:0];
                REG_STRIDE:    r_cfg.page_stride  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OWN_ADDR:  prdata = {24'd0, r_cfg.own_address};
            REG_HOST_ADDR: prdata = {24'd0, r_cfg.host_address};
            REG_STRIDE:    prdata = {24'd0, r_cfg.page_stride};
            default:       prdata = 32'd0;
        endcase
    end

    crc8fr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .i_rx_byte     (i_rx_byte),
        .i_full        (full),
        .i_own_address (r_cfg.own_address),
        .o_cmd         (push_cmd),
        .o_push        (push)
    );

    crc8fr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head     (head)
    );

    crc8fr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_res   (res)
    );

    assign o_rx_stall         = full;
    assign o_kind             = res.kind;
    assign o_data_byte        = res.data_byte;
    assign o_body_offset      = res.body_offset;
    assign o_frame_ok         = res.frame_ok;
    assign o_is_update        = res.is_update;
    assign o_write_page       = res.write_page;
    assign o_page_address     = res.page_address;
    assign o_body_length      = res.body_length;
    assign o_update_state     = res.update_state;
    assign o_sequence_number  = res.sequence_number;
    assign o_instruction_code = res.instruction_code;
    assign o_last             = res.last;

endmodule
`default_nettype wire

// ===== rtl/core/crc8fr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module crc8fr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_res_valid,
    input wire logic       i_res_stall,
    input wire logic [1:0] o_kind,
    input wire logic       o_frame_ok,
    input wire logic       o_is_update,
    input wire logic       o_write_page,
    input wire logic       o_last
);
    import crc8fr_pkg::*;

    // a held result is not withdrawn
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_res_valid && i_res_stall |=> o_res_valid, "result dropped while stalled")
    `ASSERT_CLK(a_kind_set, i_clk, i_rst_n, o_res_valid |-> o_kind != KIND_NONE, "empty result kind")
    `ASSERT_CLK(a_upd_ok, i_clk, i_rst_n, o_res_valid && o_kind == KIND_VERDICT && o_is_update |-> o_frame_ok, "update verdict on rejected frame")
    `ASSERT_CLK(a_wr_upd, i_clk, i_rst_n, o_res_valid && o_kind == KIND_VERDICT && o_write_page |-> o_is_update, "commit without update")
    // acknowledge bytes stream without gaps until the CRC byte
    `ASSERT_CLK(a_ack_run, i_clk, i_rst_n, o_res_valid && !i_res_stall && o_kind == KIND_ACK && !o_last |=> o_res_valid && o_kind == KIND_ACK, "gap inside acknowledge frame")

endmodule

bind crc8_frame_receiver_with_update_seq_unit crc8fr_checker u_crc8fr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_res_valid  (o_res_valid),
    .i_res_stall  (i_res_stall),
    .o_kind       (o_kind),
    .o_frame_ok   (o_frame_ok),
    .o_is_update  (o_is_update),
    .o_write_page (o_write_page),
    .o_last       (o_last)
);
`default_nettype wire
